FILE: rtl/sac_pkg.sv
// Package for the set-associative LRU cache controller.
// Holds geometry constants, request/response types and codes; no dependencies.
package sac_pkg;

  localparam int NUM_WAYS   = 4;
  localparam int NUM_SETS   = 64;
  localparam int LINE_BYTES = 64;
  localparam int ADDR_BITS  = 32;
  localparam int QDEPTH     = 2;

  localparam int OFF_BITS  = $clog2(LINE_BYTES);
  localparam int SET_BITS  = $clog2(NUM_SETS);
  localparam int TAG_BITS  = ADDR_BITS - OFF_BITS - SET_BITS;
  localparam int WAY_BITS  = $clog2(NUM_WAYS);
  localparam int RANK_BITS = $clog2(NUM_WAYS);
  localparam int MEM_BITS  = ADDR_BITS + 1;
  localparam int QPTR_BITS = $clog2(QDEPTH);
  localparam int QCNT_BITS = $clog2(QDEPTH + 1);

  localparam logic [MEM_BITS-1:0] MEM_SIZE_RST = MEM_BITS'(1) << ADDR_BITS;

  typedef enum logic [2:0] {
    FUNC_READ  = 3'd0,
    FUNC_WRITE = 3'd1,
    FUNC_FLUSH = 3'd2,
    FUNC_INVAL = 3'd3,
    FUNC_CLEAN = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FUNC  = 2'd2
  } status_t;

  typedef enum logic {
    BK_IDLE,
    BK_EVAL
  } bk_state_t;

  typedef struct packed {
    logic [2:0]           func;
    logic [ADDR_BITS-1:0] addr;
    logic                 write_through;
    logic                 full_line;
  } req_t;

  typedef struct packed {
    status_t              status;
    logic                 hit;
    logic [WAY_BITS-1:0]  way;
    logic [SET_BITS-1:0]  set_index;
    logic                 evict_dirty;
    logic [ADDR_BITS-1:0] evict_line_addr;
    logic                 fetch_needed;
    logic                 write_out;
    logic [ADDR_BITS-1:0] line_addr;
  } rsp_t;

  typedef struct packed {
    req_t    req;
    status_t status;
  } qent_t;

  typedef struct packed {
    logic [NUM_WAYS-1:0]                valid;
    logic [NUM_WAYS-1:0]                dirty;
    logic [NUM_WAYS-1:0][RANK_BITS-1:0] rank;
  } set_state_t;

  typedef logic [NUM_WAYS-1:0][TAG_BITS-1:0] tag_row_t;

endpackage

FILE: rtl/sac_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/sac_front.sv
// Front end: holds mem_size, accepts and classifies requests, queues them.
// Depends on sac_pkg.
module sac_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  sac_pkg::req_t                  in_req,
  input  logic                           cfg_we,
  input  logic [sac_pkg::MEM_BITS-1:0]   cfg_wdata,
  output logic                           q_valid,
  output sac_pkg::qent_t                 q_ent,
  input  logic                           q_pop
);

  logic [sac_pkg::MEM_BITS-1:0]  mem_size_r;
  sac_pkg::qent_t                qbuf_r [sac_pkg::QDEPTH];
  logic [sac_pkg::QPTR_BITS-1:0] wptr_r, rptr_r;
  logic [sac_pkg::QCNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                          push;
  sac_pkg::qent_t                ent;

  assign busy    = (cnt_r == sac_pkg::QCNT_BITS'(sac_pkg::QDEPTH));
  assign push    = start && !busy;
  assign q_valid = (cnt_r != '0);
  assign q_ent   = qbuf_r[rptr_r];

  always_comb begin
    ent.req = in_req;
    priority if (in_req.func > sac_pkg::FUNC_CLEAN) begin
      ent.status = sac_pkg::ST_FUNC;
    end else if ({1'b0, in_req.addr} >= mem_size_r) begin
      ent.status = sac_pkg::ST_RANGE;
    end else begin
      ent.status = sac_pkg::ST_OK;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !(q_pop && q_valid)) cnt_nxt = cnt_r + 1'b1;
    if (!push && q_pop && q_valid)   cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_size_r <= sac_pkg::MEM_SIZE_RST;
      wptr_r     <= '0;
      rptr_r     <= '0;
      cnt_r      <= '0;
    end else begin
      if (cfg_we) mem_size_r <= cfg_wdata;
      if (push) wptr_r <= (wptr_r == sac_pkg::QPTR_BITS'(sac_pkg::QDEPTH - 1)) ? '0 : wptr_r + 1'b1;
      if (q_pop && q_valid) begin
        rptr_r <= (rptr_r == sac_pkg::QPTR_BITS'(sac_pkg::QDEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) qbuf_r[wptr_r] <= ent;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= sac_pkg::QCNT_BITS'(sac_pkg::QDEPTH)) else $error("queue overflow");

endmodule

FILE: rtl/sac_back.sv
// Back end: reads set tags and state, applies hit/miss/LRU/dirty rules,
// writes the set back and registers the response. Depends on sac_pkg, sac_ram.
module sac_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  sac_pkg::qent_t q_ent,
  output logic           q_pop,
  output logic           out_valid,
  output sac_pkg::rsp_t  out_rsp
);

  localparam int NW = sac_pkg::NUM_WAYS;
  localparam int SB = sac_pkg::SET_BITS;
  localparam int OB = sac_pkg::OFF_BITS;
  localparam int AB = sac_pkg::ADDR_BITS;

  sac_pkg::bk_state_t  state_r, state_nxt;
  sac_pkg::qent_t      cur_r;
  logic [sac_pkg::NUM_SETS-1:0] touched_r;
  logic                out_valid_r;
  sac_pkg::rsp_t       out_r;

  logic [SB-1:0]       raddr, cur_set;
  logic [sac_pkg::TAG_BITS-1:0] cur_tag;
  sac_pkg::set_state_t st_rd, st_row, st_new;
  sac_pkg::tag_row_t   tag_rd, tag_new;
  logic                wr_en, tag_we;
  sac_pkg::rsp_t       rsp;

  logic [NW-1:0]       hitv;
  logic                found, any_inv, any_lru, is_rw;
  logic [sac_pkg::WAY_BITS-1:0] fw, iw, lw, w;
  logic [sac_pkg::RANK_BITS-1:0] rw;

  assign cur_set = cur_r.req.addr[OB +: SB];
  assign cur_tag = cur_r.req.addr[AB-1:OB+SB];

  sac_ram #(.WIDTH($bits(sac_pkg::set_state_t)), .DEPTH(sac_pkg::NUM_SETS)) u_state_ram (
    .clk, .we(wr_en), .waddr(cur_set), .wdata(st_new), .raddr(raddr), .rdata(st_rd)
  );

  sac_ram #(.WIDTH($bits(sac_pkg::tag_row_t)), .DEPTH(sac_pkg::NUM_SETS)) u_tag_ram (
    .clk, .we(tag_we), .waddr(cur_set), .wdata(tag_new), .raddr(raddr), .rdata(tag_rd)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sac_pkg::BK_IDLE: if (q_valid) state_nxt = sac_pkg::BK_EVAL;
      sac_pkg::BK_EVAL: state_nxt = sac_pkg::BK_IDLE;
      default:          state_nxt = sac_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    wr_en = 1'b0;
    unique case (state_r)
      sac_pkg::BK_IDLE: q_pop = q_valid;
      sac_pkg::BK_EVAL: wr_en = (cur_r.status == sac_pkg::ST_OK);
      default:          q_pop = 1'b0;
    endcase
  end

  assign raddr = q_ent.req.addr[OB +: SB];

  // untouched sets read as reset state
  always_comb begin
    if (touched_r[cur_set]) begin
      st_row = st_rd;
    end else begin
      st_row.valid = '0;
      st_row.dirty = '0;
      for (int i = 0; i < NW; i++) st_row.rank[i] = sac_pkg::RANK_BITS'(i);
    end
  end

  always_comb begin
    found = 1'b0; any_inv = 1'b0; any_lru = 1'b0;
    fw = '0; iw = '0; lw = '0;
    for (int i = NW - 1; i >= 0; i--) begin
      hitv[i] = st_row.valid[i] && (tag_rd[i] == cur_tag);
      if (hitv[i]) begin found = 1'b1; fw = sac_pkg::WAY_BITS'(i); end
      if (!st_row.valid[i]) begin any_inv = 1'b1; iw = sac_pkg::WAY_BITS'(i); end
      if (st_row.rank[i] == '0) begin any_lru = 1'b1; lw = sac_pkg::WAY_BITS'(i); end
    end
    if (!any_lru) lw = '0;

    is_rw   = (cur_r.req.func == sac_pkg::FUNC_READ) || (cur_r.req.func == sac_pkg::FUNC_WRITE);
    w       = found ? fw : (any_inv ? iw : lw);
    rw      = st_row.rank[w];
    st_new  = st_row;
    tag_new = tag_rd;
    tag_we  = 1'b0;

    rsp = '0;
    rsp.status    = cur_r.status;
    rsp.set_index = cur_set;
    rsp.line_addr = {cur_r.req.addr[AB-1:OB], {OB{1'b0}}};

    if (cur_r.status == sac_pkg::ST_OK) begin
      if (is_rw) begin
        rsp.hit = found;
        rsp.way = w;
        if (!found) begin
          if (!any_inv && st_row.dirty[w]) begin
            rsp.evict_dirty     = 1'b1;
            rsp.evict_line_addr = {tag_rd[w], cur_set, {OB{1'b0}}};
          end
          tag_new[w]        = cur_tag;
          tag_we            = (state_r == sac_pkg::BK_EVAL);
          st_new.valid[w]   = 1'b1;
          st_new.dirty[w]   = 1'b0;
          rsp.fetch_needed  = (cur_r.req.func == sac_pkg::FUNC_READ) || !cur_r.req.full_line;
        end
        for (int i = 0; i < NW; i++) begin
          if (st_row.rank[i] > rw) st_new.rank[i] = st_row.rank[i] - 1'b1;
        end
        st_new.rank[w] = sac_pkg::RANK_BITS'(NW - 1);
        if (cur_r.req.func == sac_pkg::FUNC_WRITE) begin
          rsp.write_out   = cur_r.req.write_through;
          st_new.dirty[w] = !cur_r.req.write_through;
        end
      end else if (found) begin
        rsp.hit          = 1'b1;
        rsp.way          = fw;
        rsp.write_out    = (cur_r.req.func != sac_pkg::FUNC_INVAL) && st_row.dirty[fw];
        st_new.dirty[fw] = 1'b0;
        if (cur_r.req.func != sac_pkg::FUNC_FLUSH) st_new.valid[fw] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sac_pkg::BK_IDLE;
      touched_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == sac_pkg::BK_EVAL);
      if (wr_en) touched_r[cur_set] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_ent;
    if (state_r == sac_pkg::BK_EVAL) out_r <= rsp;
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_r;

  a_strobe_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r) else $error("result strobe longer than one cycle");
  a_eval_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sac_pkg::BK_EVAL |=> out_valid_r) else $error("missing result after eval");
  a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.hit || out_r.evict_dirty) |-> out_r.status == sac_pkg::ST_OK)
    else $error("hit or evict on error status");
  a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.evict_dirty |-> !out_r.hit) else $error("evict on hit");

endmodule

FILE: rtl/set_assoc_lru_cache_controller.sv
// Top level of the 4-way set-associative LRU cache tag/state controller.
// Queued requests pop into the back end when idle; EVAL evaluates each and registers its result.
// One request at a time: idle reads the tag/state RAM, then EVAL writes the set back.
// A 2-entry queue decouples request accept from the back end; busy when it is full.
// Reset: synchronous; per-set state reverts at once via per-set touched bits, no clearing pass.
// Results are never stalled by the receiver. Depends on sac_pkg, sac_front, sac_back, sac_ram.
module set_assoc_lru_cache_controller (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  sac_pkg::req_t                in_req,
  output logic                         out_valid,
  output sac_pkg::rsp_t                out_rsp,
  input  logic                         cfg_we,
  input  logic [sac_pkg::MEM_BITS-1:0] cfg_wdata
);

  logic           q_valid, q_pop;
  sac_pkg::qent_t q_ent;

  sac_front u_front (
    .clk, .rst_n, .start, .busy, .in_req, .cfg_we, .cfg_wdata,
    .q_valid, .q_ent, .q_pop
  );

  sac_back u_back (
    .clk, .rst_n, .q_valid, .q_ent, .q_pop, .out_valid, .out_rsp
  );

endmodule

FILE: verif/set_assoc_lru_cache_controller_test.sv
// Testbench for the set-associative LRU cache controller: drives cache requests,
// predicts each response with a behavioral tag/LRU/dirty model and compares fields.
// Depends on sac_pkg and set_assoc_lru_cache_controller.
`timescale 1ns / 100ps

module set_assoc_lru_cache_controller_test;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  sac_pkg::req_t in_req = '0;
  logic out_valid;
  sac_pkg::rsp_t out_rsp;
  logic cfg_we = 1'b0;
  logic [sac_pkg::MEM_BITS-1:0] cfg_wdata = '0;

  set_assoc_lru_cache_controller u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_rsp(out_rsp), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // cache state shadow
  logic [sac_pkg::MEM_BITS-1:0] mem_limit;
  logic [sac_pkg::TAG_BITS-1:0] tags [sac_pkg::NUM_SETS][sac_pkg::NUM_WAYS];
  logic [sac_pkg::NUM_WAYS-1:0] vbits [sac_pkg::NUM_SETS];
  logic [sac_pkg::NUM_WAYS-1:0] dbits [sac_pkg::NUM_SETS];
  logic [sac_pkg::RANK_BITS-1:0] ranks [sac_pkg::NUM_SETS][sac_pkg::NUM_WAYS];

  sac_pkg::rsp_t pending_rsp [$];
  int mismatches = 0;
  int checked = 0;
  int sent = 0;
  int hits_seen = 0;
  int evicts_seen = 0;

  // recently used line addresses, to get hits and evictions
  logic [sac_pkg::ADDR_BITS-1:0] recent [$];

  function automatic void shadow_reset();
    mem_limit = sac_pkg::MEM_SIZE_RST;
    for (int s = 0; s < sac_pkg::NUM_SETS; s++) begin
      vbits[s] = '0;
      dbits[s] = '0;
      for (int w = 0; w < sac_pkg::NUM_WAYS; w++) begin
        tags[s][w] = '0;
        ranks[s][w] = sac_pkg::RANK_BITS'(w);
      end
    end
  endfunction

  function automatic void touch_way(int s, int w);
    logic [sac_pkg::RANK_BITS-1:0] r;
    r = ranks[s][w];
    for (int i = 0; i < sac_pkg::NUM_WAYS; i++)
      if (ranks[s][i] > r) ranks[s][i] = ranks[s][i] - 1'b1;
    ranks[s][w] = sac_pkg::RANK_BITS'(sac_pkg::NUM_WAYS - 1);
  endfunction

  function automatic sac_pkg::rsp_t cache_lookup(sac_pkg::req_t rq);
    sac_pkg::rsp_t r;
    int s;
    int found;
    int w;
    logic [sac_pkg::TAG_BITS-1:0] tg;
    r = '0;
    s = int'(rq.addr[sac_pkg::OFF_BITS +: sac_pkg::SET_BITS]);
    tg = rq.addr[sac_pkg::ADDR_BITS-1 -: sac_pkg::TAG_BITS];
    r.status = sac_pkg::ST_OK;
    r.set_index = sac_pkg::SET_BITS'(s);
    r.line_addr = {rq.addr[sac_pkg::ADDR_BITS-1:sac_pkg::OFF_BITS],
                   {sac_pkg::OFF_BITS{1'b0}}};
    found = -1;
    if (rq.func > sac_pkg::FUNC_CLEAN) begin
      r.status = sac_pkg::ST_FUNC;
    end else if ({1'b0, rq.addr} >= mem_limit) begin
      r.status = sac_pkg::ST_RANGE;
    end else begin
      for (int i = 0; i < sac_pkg::NUM_WAYS; i++)
        if (found < 0 && vbits[s][i] && tags[s][i] == tg) found = i;
      if (rq.func == sac_pkg::FUNC_READ || rq.func == sac_pkg::FUNC_WRITE) begin
        if (found >= 0) begin
          w = found;
          r.hit = 1'b1;
        end else begin
          w = -1;
          for (int i = 0; i < sac_pkg::NUM_WAYS; i++)
            if (w < 0 && !vbits[s][i]) w = i;
          if (w < 0) begin
            for (int i = 0; i < sac_pkg::NUM_WAYS; i++)
              if (w < 0 && ranks[s][i] == 0) w = i;
            if (dbits[s][w]) begin
              r.evict_dirty = 1'b1;
              r.evict_line_addr = {tags[s][w], sac_pkg::SET_BITS'(s),
                                   {sac_pkg::OFF_BITS{1'b0}}};
            end
          end
          tags[s][w] = tg;
          vbits[s][w] = 1'b1;
          dbits[s][w] = 1'b0;
          r.fetch_needed = (rq.func == sac_pkg::FUNC_READ) || !rq.full_line;
        end
        touch_way(s, w);
        r.way = sac_pkg::WAY_BITS'(w);
        if (rq.func == sac_pkg::FUNC_WRITE) begin
          if (rq.write_through) begin
            r.write_out = 1'b1;
            dbits[s][w] = 1'b0;
          end else begin
            dbits[s][w] = 1'b1;
          end
        end
      end else if (found >= 0) begin
        r.hit = 1'b1;
        r.way = sac_pkg::WAY_BITS'(found);
        if (rq.func != sac_pkg::FUNC_INVAL && dbits[s][found]) r.write_out = 1'b1;
        dbits[s][found] = 1'b0;
        if (rq.func != sac_pkg::FUNC_FLUSH) vbits[s][found] = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic int gap_len();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    return n;
  endfunction

  // drive one request; start held until accepted, dropped only for a gap
  task automatic send_request(sac_pkg::req_t rq, bit gaps = 1);
    int n;
    n = gaps ? gap_len() : 0;
    @(negedge clk);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_req <= rq;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_rsp.push_back(cache_lookup(rq));
    sent++;
    recent.push_back(rq.addr);
    if (recent.size() > 48) void'(recent.pop_front());
  endtask

  task automatic drain_requests();
    int guard;
    guard = 0;
    @(negedge clk);
    start <= 1'b0;
    while (pending_rsp.size() != 0 && guard < 10000) begin
      @(negedge clk);
      guard++;
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic write_mem_size(logic [sac_pkg::MEM_BITS-1:0] v);
    drain_requests();
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    mem_limit = v;
  endtask

  function automatic sac_pkg::req_t make_req(logic [2:0] f,
                                             logic [sac_pkg::ADDR_BITS-1:0] a,
                                             logic wt, logic fl);
    sac_pkg::req_t rq;
    rq.func = f;
    rq.addr = a;
    rq.write_through = wt;
    rq.full_line = fl;
    return rq;
  endfunction

  function automatic logic [sac_pkg::ADDR_BITS-1:0] addr_in_set(int s, int tg_sel, int off);
    return {sac_pkg::TAG_BITS'(tg_sel), sac_pkg::SET_BITS'(s), sac_pkg::OFF_BITS'(off)};
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response: %p", out_rsp);
      end else begin
        sac_pkg::rsp_t e;
        e = pending_rsp.pop_front();
        checked++;
        if (out_rsp.hit) hits_seen++;
        if (out_rsp.evict_dirty) evicts_seen++;
        if (out_rsp !== e) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: expected %p actual %p", $realtime, e, out_rsp);
        end
      end
    end
  end

  task automatic test_directed_basic();
    send_request(make_req(sac_pkg::FUNC_READ, 32'h0000_0000, 1'b0, 1'b0));
    send_request(make_req(sac_pkg::FUNC_READ, 32'h0000_0010, 1'b0, 1'b0));
    send_request(make_req(sac_pkg::FUNC_WRITE, 32'hFFFF_FFFF, 1'b0, 1'b1));
    send_request(make_req(sac_pkg::FUNC_WRITE, 32'hFFFF_FFC0, 1'b1, 1'b0));
    send_request(make_req(sac_pkg::FUNC_FLUSH, 32'hFFFF_FFFF, 1'b0, 1'b0));
    send_request(make_req(sac_pkg::FUNC_CLEAN, 32'hFFFF_FFFF, 1'b0, 1'b0));
    send_request(make_req(sac_pkg::FUNC_INVAL, 32'h0000_003F, 1'b0, 1'b0));
    send_request(make_req(sac_pkg::FUNC_FLUSH, 32'h1234_5678, 1'b0, 1'b0));
    for (int f = 5; f < 8; f++)
      send_request(make_req(3'(f), 32'hAAAA_5555, 1'b1, 1'b1));
  endtask

  // fill one set past capacity with dirty lines, then read/invalidate/flush/clean and write again
  task automatic test_eviction_set();
    for (int t = 0; t < 6; t++)
      send_request(make_req(sac_pkg::FUNC_WRITE, addr_in_set(5, t, t), 1'b0, t[0]));
    send_request(make_req(sac_pkg::FUNC_READ, addr_in_set(5, 3, 0), 1'b0, 1'b0));
    send_request(make_req(sac_pkg::FUNC_INVAL, addr_in_set(5, 4, 0), 1'b0, 1'b0));
    send_request(make_req(sac_pkg::FUNC_FLUSH, addr_in_set(5, 5, 0), 1'b0, 1'b0));
    send_request(make_req(sac_pkg::FUNC_CLEAN, addr_in_set(5, 3, 0), 1'b0, 1'b0));
    send_request(make_req(sac_pkg::FUNC_WRITE, addr_in_set(5, 9, 0), 1'b0, 1'b0));
  endtask

  task automatic test_mem_size_range();
    write_mem_size(33'h0_0000_1000);
    send_request(make_req(sac_pkg::FUNC_READ, 32'h0000_0FFF, 1'b0, 1'b0));
    send_request(make_req(sac_pkg::FUNC_READ, 32'h0000_1000, 1'b0, 1'b0));
    send_request(make_req(sac_pkg::FUNC_WRITE, 32'hFFFF_FFFF, 1'b0, 1'b0));
    write_mem_size(33'h0);
    send_request(make_req(sac_pkg::FUNC_READ, 32'h0000_0000, 1'b0, 1'b0));
    send_request(make_req(3'd6, 32'h0000_0000, 1'b0, 1'b0));
    write_mem_size(33'h1_FFFF_FFFF);
    send_request(make_req(sac_pkg::FUNC_READ, 32'hFFFF_FFFF, 1'b0, 1'b0));
  endtask

  task automatic send_random(int count);
    sac_pkg::req_t rq;
    int kind;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 99);
      rq.write_through = 1'($urandom_range(0, 1));
      rq.full_line = 1'($urandom_range(0, 1));
      if (kind < 70) rq.func = 3'($urandom_range(0, 1));
      else if (kind < 95) rq.func = 3'($urandom_range(2, 4));
      else rq.func = 3'($urandom_range(5, 7));
      kind = $urandom_range(0, 9);
      if (kind < 4 && recent.size() > 0)
        rq.addr = recent[$urandom_range(0, recent.size() - 1)] ^ 32'($urandom_range(0, 63));
      else if (kind < 8)
        rq.addr = addr_in_set($urandom_range(0, 3), $urandom_range(0, 7),
                              $urandom_range(0, 63));
      else
        rq.addr = $urandom;
      send_request(rq, 1);
    end
  endtask

  task automatic test_random_sweep();
    write_mem_size(sac_pkg::MEM_SIZE_RST);
    send_random(500);
    // hold off until everything has drained
    drain_requests();
    send_random(300);
    write_mem_size(33'h0_8000_0000);
    send_random(400);
    write_mem_size(33'h1_0000_0000);
    send_random(420);
  endtask

  initial begin
    shadow_reset();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed_basic();
    test_eviction_set();
    test_mem_size_range();
    test_random_sweep();
    drain_requests();
    $display("Sent %0d requests, checked %0d responses (%0d hits, %0d dirty evictions).",
             sent, checked, hits_seen, evicts_seen);
    if (mismatches == 0 && pending_rsp.size() == 0)
      $display("DONE: 0 errors");
    else begin
      $display("%0d mismatches, %0d responses missing", mismatches, pending_rsp.size());
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout");
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: set_assoc_lru_cache_controller.f
rtl/sac_pkg.sv
rtl/sac_ram.sv
rtl/sac_front.sv
rtl/sac_back.sv
rtl/set_assoc_lru_cache_controller.sv
verif/set_assoc_lru_cache_controller_test.sv
